// ===== rtl/fap_pkg.sv =====
// ============================================================================
// fap_pkg
// Shared constants, types and tables for the frustum axis projection terms
// pipeline.
// ============================================================================
package fap_pkg;

    // Default number of fraction bits in the scale and centre terms.
    localparam int FRAC_BITS_DEF = 16;

    // Angle input width and the clamp limit (85 degrees in Q2.16 radians).
    localparam int ANGLE_W = 18;
    localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 18'sd97223;

    // Width of the scale and centre terms.
    localparam int TERM_W = 32;

    // Four tangent lanes: old low, old high, new low, new high.
    localparam int LANES   = 4;
    localparam int L_OLO   = 0;
    localparam int L_OHI   = 1;
    localparam int L_NLO   = 2;
    localparam int L_NHI   = 3;

    // CORDIC rotation steps and the arctangent table in Q2.30.
    localparam int CORDIC_STEPS = 30;
    localparam logic [29:0] ATAN_Q30 [CORDIC_STEPS] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
        30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
        30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536,
        30'd32768, 30'd16384, 30'd8192, 30'd4096, 30'd2048,
        30'd1024, 30'd512, 30'd256, 30'd128, 30'd64,
        30'd32, 30'd16, 30'd8, 30'd4, 30'd2
    };

    // Tangent divider: |y| * 2^16 / x, 21 quotient bits.
    localparam int TAN_NW = 48;
    localparam int TAN_DW = 32;
    localparam int TAN_QB = 21;

    // Term divider: 82-bit product over 41-bit divisor, 34 quotient bits.
    localparam int TD_AW  = 32;
    localparam int TD_BW  = 50;
    localparam int TD_NW  = 82;
    localparam int TD_DW  = 41;
    localparam int TD_QB  = 34;

    // Operation codes.
    localparam logic [1:0] OP_REPLACE  = 2'd0;
    localparam logic [1:0] OP_ADD      = 2'd1;
    localparam logic [1:0] OP_RETARGET = 2'd2;

    // Item fields carried alongside the CORDIC stages.
    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] s_old;
        logic signed [31:0] c_old;
    } item_t;

    // Sideband of the tangent divider.
    typedef struct packed {
        item_t            item;
        logic [LANES-1:0] yneg;
    } tan_side_t;

    // Sideband of the term divider, used by the output stage.
    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] c_old;
        logic               err;
        logic               neg_s;
        logic               neg_c;
    } fin_t;

endpackage

// ===== rtl/fap_cordic.sv =====
// ============================================================================
// fap_cordic
// Pipelined CORDIC rotation, one step per stage, on four angle lanes.
// The last stage presents a positive x and the magnitude and sign of y.
// ============================================================================
module fap_cordic #(
    parameter int SW = 66
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic signed [fap_pkg::ANGLE_W-1:0] ang [fap_pkg::LANES],
    input  logic [SW-1:0]                      side_in,
    output logic                               out_valid,
    output logic [31:0]                        xpos [fap_pkg::LANES],
    output logic [31:0]                        ymag [fap_pkg::LANES],
    output logic [fap_pkg::LANES-1:0]          yneg,
    output logic [SW-1:0]                      side_out
);

    localparam int ST = fap_pkg::CORDIC_STEPS;
    localparam int NL = fap_pkg::LANES;

    logic [ST-1:0]      vld_reg;
    logic signed [31:0] x_reg [ST][NL];
    logic signed [31:0] y_reg [ST][NL];
    logic signed [32:0] z_reg [ST][NL];
    logic [SW-1:0]      side_reg [ST];

    logic signed [31:0] x_next [ST][NL];
    logic signed [31:0] y_next [ST][NL];
    logic signed [32:0] z_next [ST][NL];

    logic               out_valid_reg;
    logic [31:0]        xpos_reg [NL];
    logic [31:0]        ymag_reg [NL];
    logic [NL-1:0]      yneg_reg;
    logic [SW-1:0]      side_out_reg;

    // One rotation step per stage; the first stage clamps the angle.
    always_comb
    begin
        logic signed [31:0]                xi;
        logic signed [31:0]                yi;
        logic signed [32:0]                zi;
        logic signed [fap_pkg::ANGLE_W-1:0] ac;
        logic signed [32:0]                at;
        for (int k = 0; k < ST; k++)
        begin
            for (int l = 0; l < NL; l++)
            begin
                if (k == 0)
                begin
                    if (ang[l] > fap_pkg::ANGLE_LIMIT)
                        ac = fap_pkg::ANGLE_LIMIT;
                    else if (ang[l] < -fap_pkg::ANGLE_LIMIT)
                        ac = -fap_pkg::ANGLE_LIMIT;
                    else
                        ac = ang[l];
                    xi = 32'sd536870912;
                    yi = '0;
                    zi = 33'(ac) <<< 14;
                end
                else
                begin
                    ac = '0;
                    xi = x_reg[k-1][l];
                    yi = y_reg[k-1][l];
                    zi = z_reg[k-1][l];
                end
                at = $signed({3'b000, fap_pkg::ATAN_Q30[k]});
                if (!zi[32])
                begin
                    x_next[k][l] = xi - (yi >>> k);
                    y_next[k][l] = yi + (xi >>> k);
                    z_next[k][l] = zi - at;
                end
                else
                begin
                    x_next[k][l] = xi + (yi >>> k);
                    y_next[k][l] = yi - (xi >>> k);
                    z_next[k][l] = zi + at;
                end
            end
        end
    end

    // Valid bits of the stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[ST-2:0], in_valid};
            out_valid_reg <= vld_reg[ST-1];
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < ST; k++)
            begin
                for (int l = 0; l < NL; l++)
                begin
                    x_reg[k][l] <= x_next[k][l];
                    y_reg[k][l] <= y_next[k][l];
                    z_reg[k][l] <= z_next[k][l];
                end
                side_reg[k] <= (k == 0) ? side_in : side_reg[(k == 0) ? 0 : k-1];
            end
            // Output stage: x is kept at one or more, y split into sign and size.
            for (int l = 0; l < NL; l++)
            begin
                xpos_reg[l] <= (x_reg[ST-1][l] < 32'sd1) ? 32'd1 : 32'(x_reg[ST-1][l]);
                ymag_reg[l] <= y_reg[ST-1][l][31] ? 32'(-y_reg[ST-1][l])
                                                  : 32'(y_reg[ST-1][l]);
                yneg_reg[l] <= y_reg[ST-1][l][31];
            end
            side_out_reg <= side_reg[ST-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign xpos      = xpos_reg;
    assign ymag      = ymag_reg;
    assign yneg      = yneg_reg;
    assign side_out  = side_out_reg;

endmodule

// ===== rtl/fap_div.sv =====
// ============================================================================
// fap_div
// Pipelined restoring divider, one quotient bit per stage, on several lanes.
// The quotient is rounded to nearest with ties away from zero. A quotient
// that needs more than QB bits is flagged as big.
// ============================================================================
module fap_div #(
    parameter int LANES = 1,
    parameter int NW    = 48,
    parameter int DW    = 32,
    parameter int QB    = 21,
    parameter int SW    = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num [LANES],
    input  logic [DW-1:0] den [LANES],
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QB:0]   quo [LANES],
    output logic [LANES-1:0] big,
    output logic [SW-1:0] side_out
);

    localparam int CW = (NW > DW + QB) ? NW : DW + QB;

    logic [QB:0]       vld_reg;
    logic [DW-1:0]     rem_reg  [QB+1][LANES];
    logic [QB-1:0]     nq_reg   [QB+1][LANES];
    logic [DW-1:0]     den_reg  [QB+1][LANES];
    logic [LANES-1:0]  big_reg  [QB+1];
    logic [SW-1:0]     side_reg [QB+1];

    logic [DW-1:0]     rem_next [QB+1][LANES];
    logic [QB-1:0]     nq_next  [QB+1][LANES];

    logic              out_valid_reg;
    logic [QB:0]       quo_reg [LANES];
    logic [LANES-1:0]  big_out_reg;
    logic [SW-1:0]     side_out_reg;

    // Stage zero loads the top of the dividend; later stages take one bit each.
    always_comb
    begin
        logic [DW:0] trial;
        logic        ge;
        for (int l = 0; l < LANES; l++)
        begin
            rem_next[0][l] = DW'(num[l] >> QB);
            nq_next[0][l]  = num[l][QB-1:0];
        end
        for (int k = 1; k <= QB; k++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                trial = {rem_reg[k-1][l], nq_reg[k-1][l][QB-1]};
                ge    = (trial >= {1'b0, den_reg[k-1][l]});
                rem_next[k][l] = ge ? DW'(trial - {1'b0, den_reg[k-1][l]}) : trial[DW-1:0];
                nq_next[k][l]  = {nq_reg[k-1][l][QB-2:0], ge};
            end
        end
    end

    // Valid bits of the stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[QB-1:0], in_valid};
            out_valid_reg <= vld_reg[QB];
        end
    end

    // Stage payload and rounding at the output.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                big_reg[0][l] <= (CW'(num[l]) >= (CW'(den[l]) << QB));
                den_reg[0][l] <= den[l];
            end
            side_reg[0] <= side_in;
            for (int k = 1; k <= QB; k++)
            begin
                for (int l = 0; l < LANES; l++)
                    den_reg[k][l] <= den_reg[k-1][l];
                big_reg[k]  <= big_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
            for (int k = 0; k <= QB; k++)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[k][l] <= rem_next[k][l];
                    nq_reg[k][l]  <= nq_next[k][l];
                end
            end
            for (int l = 0; l < LANES; l++)
            begin
                quo_reg[l] <= (QB+1)'(nq_reg[QB][l]) +
                              (QB+1)'({rem_reg[QB][l], 1'b0} >= {1'b0, den_reg[QB][l]});
            end
            big_out_reg  <= big_reg[QB];
            side_out_reg <= side_reg[QB];
        end
    end

    assign out_valid = out_valid_reg;
    assign quo       = quo_reg;
    assign big       = big_out_reg;
    assign side_out  = side_out_reg;

endmodule

// ===== rtl/fap_terms.sv =====
// ============================================================================
// fap_terms
// Forms spans and sums of the tangents, the cross term of a retarget, and the
// products and divisors that the term divider needs, over six stages.
// ============================================================================
module fap_terms #(
    parameter int FRAC_BITS = fap_pkg::FRAC_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [fap_pkg::TAN_QB:0] tq [fap_pkg::LANES],
    input  fap_pkg::tan_side_t       side_in,
    output logic                     out_valid,
    output logic [fap_pkg::TD_NW-1:0] num [2],
    output logic [fap_pkg::TD_DW-1:0] den [2],
    output fap_pkg::fin_t            fin
);

    localparam int NL = fap_pkg::LANES;
    localparam int AW = fap_pkg::TD_AW;
    localparam int BW = fap_pkg::TD_BW;
    localparam int HB = BW / 2;

    logic [5:0] vld_reg;

    // Stage 1: signed tangents, spans and sums.
    logic signed [23:0] tv [NL];
    fap_pkg::item_t     it1_reg;
    logic signed [23:0] nspan_reg, nsum_reg, ospan_reg, osum_reg;

    // Stage 2: cross products and magnitudes.
    logic [1:0]         op2_reg;
    logic signed [31:0] c2_reg;
    logic signed [47:0] p1_reg, p2_reg;
    logic [23:0]        m2_reg, nsum_mag_reg, ospan_mag_reg;
    logic [31:0]        smag_reg;
    logic               err2_reg, nneg2_reg, sneg2_reg, nsneg2_reg, osneg2_reg;

    // Stage 3: cross term of a retarget.
    logic [1:0]         op3_reg;
    logic signed [31:0] c3_reg;
    logic signed [48:0] d3_reg;
    logic [23:0]        m3_reg, nsum_mag3_reg, ospan_mag3_reg;
    logic [31:0]        smag3_reg;
    logic               err3_reg, nneg3_reg, sneg3_reg, nsneg3_reg, osneg3_reg;

    // Stage 4: operands selected by operation.
    logic [AW-1:0]      a4_reg [2];
    logic [BW-1:0]      b4_reg [2];
    logic [fap_pkg::TD_DW-1:0] den4_reg [2];
    fap_pkg::fin_t      fin4_reg;

    // Stage 5: partial products.
    logic [AW+HB-1:0]   pl5_reg [2];
    logic [AW+HB-1:0]   ph5_reg [2];
    logic [fap_pkg::TD_DW-1:0] den5_reg [2];
    fap_pkg::fin_t      fin5_reg;

    // Stage 6: full products.
    logic [fap_pkg::TD_NW-1:0] num6_reg [2];
    logic [fap_pkg::TD_DW-1:0] den6_reg [2];
    fap_pkg::fin_t      fin6_reg;

    // Operand selection for stage 4.
    logic [48:0]        dmag;
    logic               dneg;
    logic               retarget;

    always_comb
    begin
        for (int l = 0; l < NL; l++)
            tv[l] = side_in.yneg[l] ? 24'(24'd0 - 24'(tq[l])) : 24'(tq[l]);
        dneg     = d3_reg[48];
        dmag     = dneg ? 49'(-d3_reg) : 49'(d3_reg);
        retarget = (op3_reg == fap_pkg::OP_RETARGET);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[4:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Stage 1.
            it1_reg   <= side_in.item;
            nspan_reg <= tv[fap_pkg::L_NHI] - tv[fap_pkg::L_NLO];
            nsum_reg  <= tv[fap_pkg::L_NHI] + tv[fap_pkg::L_NLO];
            ospan_reg <= tv[fap_pkg::L_OHI] - tv[fap_pkg::L_OLO];
            osum_reg  <= tv[fap_pkg::L_OHI] + tv[fap_pkg::L_OLO];

            // Stage 2.
            op2_reg       <= it1_reg.op;
            c2_reg        <= it1_reg.c_old;
            p1_reg        <= osum_reg * nspan_reg;
            p2_reg        <= ospan_reg * nsum_reg;
            m2_reg        <= nspan_reg[23] ? 24'(-nspan_reg) : 24'(nspan_reg);
            nsum_mag_reg  <= nsum_reg[23] ? 24'(-nsum_reg) : 24'(nsum_reg);
            ospan_mag_reg <= ospan_reg[23] ? 24'(-ospan_reg) : 24'(ospan_reg);
            smag_reg      <= it1_reg.s_old[31] ? 32'(-it1_reg.s_old) : 32'(it1_reg.s_old);
            err2_reg      <= (nspan_reg == '0);
            nneg2_reg     <= nspan_reg[23];
            sneg2_reg     <= it1_reg.s_old[31];
            nsneg2_reg    <= nsum_reg[23];
            osneg2_reg    <= ospan_reg[23];

            // Stage 3.
            op3_reg        <= op2_reg;
            c3_reg         <= c2_reg;
            d3_reg         <= 49'(p1_reg) - 49'(p2_reg);
            m3_reg         <= m2_reg;
            nsum_mag3_reg  <= nsum_mag_reg;
            ospan_mag3_reg <= ospan_mag_reg;
            smag3_reg      <= smag_reg;
            err3_reg       <= err2_reg;
            nneg3_reg      <= nneg2_reg;
            sneg3_reg      <= sneg2_reg;
            nsneg3_reg     <= nsneg2_reg;
            osneg3_reg     <= osneg2_reg;

            // Stage 4: scale lane 0, centre lane 1.
            if (retarget)
            begin
                a4_reg[0]      <= smag3_reg;
                b4_reg[0]      <= BW'(ospan_mag3_reg);
                den4_reg[0]    <= fap_pkg::TD_DW'(m3_reg);
                a4_reg[1]      <= smag3_reg;
                b4_reg[1]      <= BW'(dmag);
                den4_reg[1]    <= {m3_reg, 17'b0};
                fin4_reg.neg_s <= sneg3_reg != (osneg3_reg != nneg3_reg);
                fin4_reg.neg_c <= sneg3_reg != (dneg != nneg3_reg);
            end
            else
            begin
                a4_reg[0]      <= AW'(64'd1 << (FRAC_BITS + 1));
                b4_reg[0]      <= BW'(64'd65536);
                den4_reg[0]    <= fap_pkg::TD_DW'(m3_reg);
                a4_reg[1]      <= AW'(64'd1 << FRAC_BITS);
                b4_reg[1]      <= BW'(nsum_mag3_reg);
                den4_reg[1]    <= fap_pkg::TD_DW'(m3_reg);
                fin4_reg.neg_s <= sneg3_reg != nneg3_reg;
                fin4_reg.neg_c <= (!sneg3_reg) != (nsneg3_reg != nneg3_reg);
            end
            fin4_reg.op    <= op3_reg;
            fin4_reg.c_old <= c3_reg;
            fin4_reg.err   <= err3_reg;

            // Stage 5 and 6: the product is split in halves of the b operand.
            for (int j = 0; j < 2; j++)
            begin
                pl5_reg[j]  <= (AW+HB)'(a4_reg[j]) * (AW+HB)'(b4_reg[j][HB-1:0]);
                ph5_reg[j]  <= (AW+HB)'(a4_reg[j]) * (AW+HB)'(b4_reg[j][BW-1:HB]);
                den5_reg[j] <= den4_reg[j];
                num6_reg[j] <= fap_pkg::TD_NW'(pl5_reg[j]) +
                               (fap_pkg::TD_NW'(ph5_reg[j]) << HB);
                den6_reg[j] <= den5_reg[j];
            end
            fin5_reg <= fin4_reg;
            fin6_reg <= fin5_reg;
        end
    end

    assign out_valid = vld_reg[5];
    assign num       = num6_reg;
    assign den       = den6_reg;
    assign fin       = fin6_reg;

endmodule

// ===== rtl/frustum_axis_projection_terms_core.sv =====
// ============================================================================
// frustum_axis_projection_terms_core
// Scale and centre terms of one projection axis from its edge angles, with
// CORDIC tangents, pipelined dividers and saturation to 32 bits.
// ============================================================================
//
//  Channel   Direction  Payload (lowest bit first)
//  s_axis    in         op, prev_scale, prev_centre, old_lo/hi_angle, new_lo/hi_angle
//  m_axis    out        out_scale, out_centre, span_error, saturated
//
//  One transaction enters per cycle while the output is not stalled; each result
//  passes 31 CORDIC stages, 23 tangent divider stages, 6 term stages, 36 term
//  divider stages and the output register. The one-bit-per-stage dividers
//  set most of that depth.
//  Reset clears only the valid bits. A stall at the output freezes the whole
//  pipeline together, so no transaction is dropped or repeated.
//
module frustum_axis_projection_terms_core #(
    parameter int FRAC_BITS = fap_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // op[1:0], prev_scale[33:2], prev_centre[65:34], old_lo_angle[83:66],
    // old_hi_angle[101:84], new_lo_angle[119:102], new_hi_angle[137:120], zero pad
    input  logic [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_scale[31:0], out_centre[63:32], span_error[64], saturated[65], zero pad
    output logic [71:0]  m_axis_tdata
);

    localparam int NL = fap_pkg::LANES;
    localparam int TW = fap_pkg::TERM_W;

    logic en;

    // Input unpacking.
    logic signed [fap_pkg::ANGLE_W-1:0] ang_in [NL];
    fap_pkg::item_t                     item_in;

    // CORDIC outputs.
    logic                  cor_valid;
    logic [31:0]           cor_x [NL];
    logic [31:0]           cor_y [NL];
    logic [NL-1:0]         cor_yneg;
    fap_pkg::item_t        cor_item;
    fap_pkg::tan_side_t    tan_side;
    logic [fap_pkg::TAN_NW-1:0] tan_num [NL];
    logic [fap_pkg::TAN_DW-1:0] tan_den [NL];

    // Tangent divider outputs.
    logic                       tan_valid;
    logic [fap_pkg::TAN_QB:0]   tan_q [NL];
    logic [NL-1:0]              tan_big;
    fap_pkg::tan_side_t         tan_side_out;

    // Term stage outputs.
    logic                       trm_valid;
    logic [fap_pkg::TD_NW-1:0]  trm_num [2];
    logic [fap_pkg::TD_DW-1:0]  trm_den [2];
    fap_pkg::fin_t              trm_fin;

    // Term divider outputs.
    logic                       td_valid;
    logic [fap_pkg::TD_QB:0]    td_q [2];
    logic [1:0]                 td_big;
    fap_pkg::fin_t              td_fin;

    // Output register.
    logic                       out_valid_reg;
    logic signed [TW-1:0]       out_scale_reg, out_scale_next;
    logic signed [TW-1:0]       out_centre_reg, out_centre_next;
    logic                       out_err_reg, out_err_next;
    logic                       out_sat_reg, out_sat_next;

    // The pipeline moves whenever the output register is free or being taken.
    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    assign item_in.op    = s_axis_tdata[1:0];
    assign item_in.s_old = s_axis_tdata[33:2];
    assign item_in.c_old = s_axis_tdata[65:34];
    assign ang_in[fap_pkg::L_OLO] = s_axis_tdata[83:66];
    assign ang_in[fap_pkg::L_OHI] = s_axis_tdata[101:84];
    assign ang_in[fap_pkg::L_NLO] = s_axis_tdata[119:102];
    assign ang_in[fap_pkg::L_NHI] = s_axis_tdata[137:120];

    fap_cordic #(
        .SW ($bits(fap_pkg::item_t))
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .ang       (ang_in),
        .side_in   (item_in),
        .out_valid (cor_valid),
        .xpos      (cor_x),
        .ymag      (cor_y),
        .yneg      (cor_yneg),
        .side_out  (cor_item)
    );

    // Tangent numerator is |y| scaled by 2^16.
    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            tan_num[l] = {cor_y[l], 16'b0};
            tan_den[l] = cor_x[l];
        end
        tan_side.item = cor_item;
        tan_side.yneg = cor_yneg;
    end

    fap_div #(
        .LANES (NL),
        .NW    (fap_pkg::TAN_NW),
        .DW    (fap_pkg::TAN_DW),
        .QB    (fap_pkg::TAN_QB),
        .SW    ($bits(fap_pkg::tan_side_t))
    ) u_tan_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cor_valid),
        .num       (tan_num),
        .den       (tan_den),
        .side_in   (tan_side),
        .out_valid (tan_valid),
        .quo       (tan_q),
        .big       (tan_big),
        .side_out  (tan_side_out)
    );

    fap_terms #(
        .FRAC_BITS (FRAC_BITS)
    ) u_terms (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (tan_valid),
        .tq        (tan_q),
        .side_in   (tan_side_out),
        .out_valid (trm_valid),
        .num       (trm_num),
        .den       (trm_den),
        .fin       (trm_fin)
    );

    fap_div #(
        .LANES (2),
        .NW    (fap_pkg::TD_NW),
        .DW    (fap_pkg::TD_DW),
        .QB    (fap_pkg::TD_QB),
        .SW    ($bits(fap_pkg::fin_t))
    ) u_term_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (trm_valid),
        .num       (trm_num),
        .den       (trm_den),
        .side_in   (trm_fin),
        .out_valid (td_valid),
        .quo       (td_q),
        .big       (td_big),
        .side_out  (td_fin)
    );

    // Clamp a wide signed value to the 32-bit range; the top bit is the flag.
    function automatic logic [TW:0] sat_term(input logic signed [37:0] v);
        logic [TW:0] r;
        if (v > 38'sd2147483647)
            r = {1'b1, 32'h7FFF_FFFF};
        else if (v < -38'sd2147483648)
            r = {1'b1, 32'h8000_0000};
        else
            r = {1'b0, v[TW-1:0]};
        return r;
    endfunction

    // Signs, centre offset and saturation of the two quotients.
    always_comb
    begin
        logic [fap_pkg::TD_QB:0] qs;
        logic [fap_pkg::TD_QB:0] qc;
        logic signed [37:0]      vs;
        logic signed [37:0]      vc;
        logic [TW:0]             rs;
        logic [TW:0]             rc;
        qs = td_big[0] ? (fap_pkg::TD_QB+1)'(1) << fap_pkg::TD_QB : td_q[0];
        qc = td_big[1] ? (fap_pkg::TD_QB+1)'(1) << fap_pkg::TD_QB : td_q[1];
        vs = td_fin.neg_s ? -$signed(38'(qs)) : $signed(38'(qs));
        vc = td_fin.neg_c ? -$signed(38'(qc)) : $signed(38'(qc));
        if (td_fin.op == fap_pkg::OP_ADD || td_fin.op == fap_pkg::OP_RETARGET)
            vc = vc + 38'(td_fin.c_old);
        rs = sat_term(vs);
        rc = sat_term(vc);
        if (td_fin.op != fap_pkg::OP_REPLACE && td_fin.op != fap_pkg::OP_ADD &&
            td_fin.op != fap_pkg::OP_RETARGET)
        begin
            out_scale_next  = '0;
            out_centre_next = '0;
            out_err_next    = 1'b0;
            out_sat_next    = 1'b0;
        end
        else if (td_fin.err)
        begin
            out_scale_next  = '0;
            out_centre_next = '0;
            out_err_next    = 1'b1;
            out_sat_next    = 1'b0;
        end
        else
        begin
            out_scale_next  = rs[TW-1:0];
            out_centre_next = rc[TW-1:0];
            out_err_next    = 1'b0;
            out_sat_next    = rs[TW] | rc[TW];
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= td_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_scale_reg  <= out_scale_next;
            out_centre_reg <= out_centre_next;
            out_err_reg    <= out_err_next;
            out_sat_reg    <= out_sat_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_sat_reg, out_err_reg, out_centre_reg, out_scale_reg};

    // A held result stops the intake.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |-> !s_axis_tready)
        else $error("Input taken while the output is stalled.");

    // A span error comes with zero terms and no saturation.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_err_reg |->
            out_scale_reg == '0 && out_centre_reg == '0 && !out_sat_reg)
        else $error("Span error with non-zero terms.");

    // A saturated result has a term at one end of the range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_sat_reg |->
            out_scale_reg == 32'sh7FFF_FFFF || out_scale_reg == 32'sh8000_0000 ||
            out_centre_reg == 32'sh7FFF_FFFF || out_centre_reg == 32'sh8000_0000)
        else $error("Saturation flag without a clamped term.");

    // Tangents of clamped angles always fit the tangent quotient width.
    assert property (@(posedge clk) disable iff (!rst_n)
        tan_valid |-> tan_big == '0)
        else $error("Tangent quotient out of range.");

endmodule
